>>> sv/mms_pkg.sv
`default_nettype none

package mms_pkg;

    // system call codes
    localparam logic [1:0] KIND_SEND    = 2'd0;
    localparam logic [1:0] KIND_RECEIVE = 2'd1;
    localparam logic [1:0] KIND_EXIT    = 2'd2;

    // width of every value field on the ports
    localparam int PORT_VALUE_W = 32;

    typedef enum logic [1:0] {
        THR_READY   = 2'd0,
        THR_BLOCKED = 2'd1,
        THR_DEAD    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        HALT_NONE     = 2'd0,
        HALT_ALL_DEAD = 2'd1,
        HALT_DEADLOCK = 2'd2
    } halt_t;

    typedef struct packed {
        logic [1:0]                     kind;
        logic                           target_thread;
        logic signed [PORT_VALUE_W-1:0] message_value;
    } mms_in_t;

    typedef struct packed {
        logic                           reply_valid;
        logic signed [PORT_VALUE_W-1:0] reply_value;
        logic                           woken_valid;
        logic                           woken_thread;
        logic signed [PORT_VALUE_W-1:0] woken_value;
        logic                           running_thread;
        logic                           mailbox_overflow;
        logic [1:0]                     halt_status;
    } mms_out_t;

endpackage

`default_nettype wire

>>> sv/mms_ram.sv
`default_nettype none

module mms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // read returns the old contents on a same-address write
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> sv/mms_sched.sv
`default_nettype none

module mms_sched
    import mms_pkg::*;
#(
    parameter int THREAD_COUNT = 2
) (
    input  wire status_t                              status [THREAD_COUNT],
    input  wire logic [$clog2(THREAD_COUNT)-1:0]      cur_thread,
    output logic      [$clog2(THREAD_COUNT)-1:0]      next_thread,
    output halt_t                                     halt_code
);

    localparam int TID_W = $clog2(THREAD_COUNT);

    logic                   all_dead;
    logic                   found;
    logic [TID_W-1:0]       pick;
    logic [TID_W:0]         sum;

    always_comb begin
        all_dead = 1'b1;
        for (int t = 0; t < THREAD_COUNT; t++) begin
            if (status[t] != THR_DEAD) begin
                all_dead = 1'b0;
            end
        end

        // priority pick, nearest thread after the caller wins
        found = 1'b0;
        pick  = cur_thread;
        sum   = '0;
        for (int i = THREAD_COUNT - 1; i >= 1; i--) begin
            sum = {1'b0, cur_thread} + (TID_W + 1)'(i);
            if (sum >= (TID_W + 1)'(THREAD_COUNT)) begin
                sum = sum - (TID_W + 1)'(THREAD_COUNT);
            end
            if (status[sum[TID_W-1:0]] == THR_READY) begin
                found = 1'b1;
                pick  = sum[TID_W-1:0];
            end
        end

        next_thread = cur_thread;
        halt_code   = HALT_NONE;
        if (all_dead) begin
            halt_code = HALT_ALL_DEAD;
        end else if (status[cur_thread] != THR_READY) begin
            if (found) begin
                next_thread = pick;
            end else begin
                halt_code = HALT_DEADLOCK;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/mailbox_message_scheduler.sv
// Thread mailbox and round-robin scheduler. Each input transfer is one system
// call (send, receive or exit) from the running thread, and each call gives
// exactly one result transfer: the value popped for a receive, the thread
// woken by a send with its value, an overflow flag for a send to a full
// mailbox (the value is dropped), the thread that runs next and the sticky
// halt status (all threads dead, or deadlock). Once halted, calls are ignored
// and the result repeats the halt status. A call is taken every cycle when
// the result side keeps up; the result passes the input register, then the
// result register, before it is offered on the output. Rate is set by the
// scheduler feedback: each call's thread status, mailbox pointers and
// running thread are written back in the same cycle the call is processed.
// Mailbox values sit in one RAM whose read address is computed ahead from
// the next head pointer of the next running thread, with a forward path for
// a value written to that slot in the same cycle.
`default_nettype none

module mailbox_message_scheduler
    import mms_pkg::*;
#(
    parameter int THREAD_COUNT  = 2,
    parameter int MAILBOX_DEPTH = 4,
    parameter int VALUE_WIDTH   = 32
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire mms_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output mms_out_t      m_data
);

    localparam int TID_W     = $clog2(THREAD_COUNT);
    localparam int SLOT_W    = $clog2(MAILBOX_DEPTH);
    localparam int ADDR_W    = TID_W + SLOT_W;
    localparam int RAM_DEPTH = THREAD_COUNT * (2 ** SLOT_W);

    // pointer = {wrap phase, slot}; empty when equal, full when slots match
    // and phases differ
    typedef logic [SLOT_W:0] ptr_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p[SLOT_W-1:0] == SLOT_W'(MAILBOX_DEPTH - 1)) begin
            r = {~p[SLOT_W], {SLOT_W{1'b0}}};
        end else begin
            r = {p[SLOT_W], p[SLOT_W-1:0] + 1'b1};
        end
        return r;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] to_store(input logic [PORT_VALUE_W-1:0] v);
        logic [VALUE_WIDTH+PORT_VALUE_W-1:0] ext;
        ext = {{VALUE_WIDTH{1'b0}}, v};
        return ext[VALUE_WIDTH-1:0];
    endfunction

    function automatic logic [PORT_VALUE_W-1:0] to_port(input logic [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH+PORT_VALUE_W-1:0] ext;
        ext = {{PORT_VALUE_W{1'b0}}, v};
        return ext[PORT_VALUE_W-1:0];
    endfunction

    // handshake and pipeline registers
    logic      in_valid_reg, in_valid_next;
    mms_in_t   in_reg;
    logic      out_valid_reg, out_valid_next;
    mms_out_t  out_reg;
    mms_out_t  call_res;
    mms_out_t  res;
    logic      advance;

    // scheduler state
    status_t          status_reg  [THREAD_COUNT];
    status_t          status_next [THREAD_COUNT];
    ptr_t             head_reg    [THREAD_COUNT];
    ptr_t             head_next   [THREAD_COUNT];
    ptr_t             tail_reg    [THREAD_COUNT];
    ptr_t             tail_next   [THREAD_COUNT];
    logic [TID_W-1:0] cur_reg, cur_next;
    halt_t            halt_reg, halt_next;

    // mailbox storage and read-ahead forwarding
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_wr_addr;
    logic [VALUE_WIDTH-1:0] ram_wr_data;
    logic [ADDR_W-1:0]      ram_rd_addr;
    logic [VALUE_WIDTH-1:0] ram_rd_data;
    logic                   fwd_hit_reg;
    logic [VALUE_WIDTH-1:0] fwd_data_reg;
    logic [VALUE_WIDTH-1:0] head_data;

    logic [TID_W-1:0]       dst;
    logic [VALUE_WIDTH-1:0] val;
    logic                   active;
    logic [TID_W-1:0]       sched_thread;
    halt_t                  sched_halt;
    ptr_t                   rd_ptr;

    // the result register frees as soon as the sink takes it
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign active    = advance && (halt_reg == HALT_NONE);
    assign dst       = TID_W'(in_reg.target_thread);
    assign val       = to_store(in_reg.message_value);
    assign head_data = fwd_hit_reg ? fwd_data_reg : ram_rd_data;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // system call decode and mailbox update
    always_comb begin
        status_next = status_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        ram_we      = 1'b0;
        ram_wr_addr = {dst, tail_reg[dst][SLOT_W-1:0]};
        ram_wr_data = val;
        call_res    = '0;

        if (active) begin
            case (in_reg.kind)
                KIND_SEND: begin
                    if (status_reg[dst] == THR_BLOCKED) begin
                        // hand the value straight over and wake the target
                        status_next[dst]      = THR_READY;
                        call_res.woken_valid  = 1'b1;
                        call_res.woken_thread = in_reg.target_thread;
                        call_res.woken_value  = to_port(val);
                    end else if ((head_reg[dst][SLOT_W-1:0] == tail_reg[dst][SLOT_W-1:0]) &&
                                 (head_reg[dst][SLOT_W] != tail_reg[dst][SLOT_W])) begin
                        call_res.mailbox_overflow = 1'b1;
                    end else begin
                        ram_we         = 1'b1;
                        tail_next[dst] = ptr_inc(tail_reg[dst]);
                    end
                end
                KIND_RECEIVE: begin
                    if (head_reg[cur_reg] != tail_reg[cur_reg]) begin
                        call_res.reply_valid = 1'b1;
                        call_res.reply_value = to_port(head_data);
                        head_next[cur_reg]   = ptr_inc(head_reg[cur_reg]);
                    end else begin
                        status_next[cur_reg] = THR_BLOCKED;
                    end
                end
                KIND_EXIT: begin
                    status_next[cur_reg] = THR_DEAD;
                end
                default: begin
                    // unused code, no operation
                end
            endcase
        end
    end

    mms_sched #(
        .THREAD_COUNT (THREAD_COUNT)
    ) u_sched (
        .status      (status_next),
        .cur_thread  (cur_reg),
        .next_thread (sched_thread),
        .halt_code   (sched_halt)
    );

    always_comb begin
        cur_next  = cur_reg;
        halt_next = halt_reg;
        if (active) begin
            cur_next  = sched_thread;
            halt_next = sched_halt;
        end
        res                = call_res;
        res.running_thread = cur_next[0];
        res.halt_status    = halt_next;

        // read ahead: slot at the head of whichever thread runs next
        rd_ptr      = head_next[cur_next];
        ram_rd_addr = {cur_next, rd_ptr[SLOT_W-1:0]};
    end

    mms_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (RAM_DEPTH)
    ) u_mailbox_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            cur_reg       <= '0;
            halt_reg      <= HALT_NONE;
            for (int t = 0; t < THREAD_COUNT; t++) begin
                status_reg[t] <= THR_READY;
                head_reg[t]   <= '0;
                tail_reg[t]   <= '0;
            end
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            // a write landing on the slot being read ahead wins over the ram
            fwd_hit_reg   <= ram_we && (ram_wr_addr == ram_rd_addr);
            cur_reg       <= cur_next;
            halt_reg      <= halt_next;
            status_reg    <= status_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        fwd_data_reg <= ram_wr_data;
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= res;
        end
    end

endmodule

`default_nettype wire
